### rtl/idl_pkg.sv
// Shared types, constants and helper functions for the include directive locator.
// This file depends on nothing else; the locator and its checker import it.
package idl_pkg;

    // Largest text size; positions and offsets stop at this value.
    localparam int unsigned MAX_TEXT_BYTES = 1048576;

    // Width of every position, length and line number field.
    localparam int unsigned POS_W = 21;

    // Stream payload widths. The result data is padded with zeros to whole bytes.
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_FLDS_W = 5 * POS_W;
    localparam int unsigned OUT_DATA_W = ((OUT_FLDS_W + 7) / 8) * 8;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [7:0]       char_t;
    typedef logic [2:0]       kw_idx_t;

    localparam pos_t POS_MAX      = pos_t'(MAX_TEXT_BYTES);
    localparam pos_t LINE_MAX     = pos_t'(MAX_TEXT_BYTES + 1);
    localparam pos_t LINE_FIRST   = pos_t'(1);
    localparam kw_idx_t KW_LAST   = kw_idx_t'(6);

    // Character codes that the scanner looks for.
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_LF    = 8'h0A;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_HASH  = 8'h23;
    localparam char_t CH_QUOTE = 8'h22;

    // Scan phases of one line, one-hot.
    typedef enum logic [7:0] {
        PH_LINE_BLANKS = 8'b0000_0001,
        PH_HASH_BLANKS = 8'b0000_0010,
        PH_KEYWORD     = 8'b0000_0100,
        PH_SEPARATOR   = 8'b0000_1000,
        PH_NAME_BLANKS = 8'b0001_0000,
        PH_NAME        = 8'b0010_0000,
        PH_MATCHED     = 8'b0100_0000,
        PH_TO_EOL      = 8'b1000_0000
    } phase_t;

    // Kind of the line break seen in the previous byte.
    typedef enum logic [1:0] {
        BRK_NONE = 2'd0,
        BRK_CR   = 2'd1,
        BRK_LF   = 2'd2
    } brk_t;

    // Letters of the keyword, indexed from zero.
    function automatic char_t keyword_char(input kw_idx_t idx);
        char_t c;
        unique case (idx)
            3'd0:    c = 8'h69; // i
            3'd1:    c = 8'h6E; // n
            3'd2:    c = 8'h63; // c
            3'd3:    c = 8'h6C; // l
            3'd4:    c = 8'h75; // u
            3'd5:    c = 8'h64; // d
            3'd6:    c = 8'h65; // e
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Position plus one, held at the maximum text size.
    function automatic pos_t plus_one_sat(input pos_t v);
        pos_t r;
        r = (v < POS_MAX) ? v + pos_t'(1) : POS_MAX;
        return r;
    endfunction

    function automatic logic is_blank(input char_t c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

### rtl/include_directive_locator.sv
// Streaming scanner that reports each include directive line of a source text.
// Depends on idl_pkg for types, character codes and the saturating increment.
//
// The block takes one text byte per clock cycle, back to back, and can give one
// request on the result side per byte. Each byte passes an input register,
// parser logic that updates a small set of running registers, and a result
// register; a directive enters the result register when the byte that ends its
// line (the break byte or the byte marked last) leaves the input register. A result
// stalled on the master side holds the input side only when the byte waiting in
// the input register would itself give a result; other bytes keep flowing.
// The last byte of a text returns all counters to their start values, and the
// next byte begins a new text with line number 1 at offset 0. Offsets stop at
// MAX_TEXT_BYTES and set too_long, as does a full line counter.
module include_directive_locator
    import idl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Text input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // [7:0] text_byte
    input  logic                  s_tlast,  // is_final
    // Directive results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [20:0] line_begin, [41:21] line_finish, [62:42] name_offset,
    // [83:63] name_length, [104:84] following_line, [111:105] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]            m_tuser   // [0] too_long
);

    // Input register
    logic   in_valid_reg;
    char_t  in_byte_reg;
    logic   in_last_reg;

    // Running parser state
    phase_t  phase_reg,  phase_next;
    kw_idx_t kw_reg,     kw_next;
    pos_t    pos_reg,    pos_next;
    pos_t    line_reg,   line_next;
    pos_t    begin_reg,  begin_next;
    pos_t    qs_reg,     qs_next;
    pos_t    ql_reg,     ql_next;
    brk_t    brk_reg,    brk_next;
    logic    sat_reg,    sat_next;

    // Result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_long_reg;

    logic  emit;
    pos_t  finish;
    pos_t  qs_out;
    pos_t  ql_out;
    logic  sat_pos;
    pos_t  pos_inc;
    logic  is_brk;
    logic  pair;
    logic  advance;
    char_t b;

    // Parser step for the byte in the input register.
    always_comb
    begin
        b       = in_byte_reg;
        sat_pos = sat_reg | (pos_reg >= POS_MAX);
        pos_inc = plus_one_sat(pos_reg);
        is_brk  = (b == CH_CR) || (b == CH_LF);
        pair    = ((brk_reg == BRK_CR) && (b == CH_LF)) ||
                  ((brk_reg == BRK_LF) && (b == CH_CR));

        phase_next = phase_reg;
        kw_next    = kw_reg;
        line_next  = line_reg;
        begin_next = begin_reg;
        qs_next    = qs_reg;
        ql_next    = ql_reg;
        brk_next   = brk_reg;
        sat_next   = sat_pos;
        emit       = 1'b0;
        finish     = pos_reg;

        if (pair)
        begin
            // Second half of a CR LF or LF CR break.
            brk_next   = BRK_NONE;
            begin_next = pos_inc;
        end
        else if (is_brk)
        begin
            // A line break closes the line and reports a matched directive.
            emit       = (phase_reg == PH_MATCHED);
            brk_next   = (b == CH_CR) ? BRK_CR : BRK_LF;
            if (line_reg < LINE_MAX)
            begin
                line_next = line_reg + pos_t'(1);
            end
            else
            begin
                sat_next = 1'b1;
            end
            begin_next = pos_inc;
            phase_next = PH_LINE_BLANKS;
            kw_next    = '0;
        end
        else
        begin
            brk_next = BRK_NONE;
            unique case (phase_reg)
                PH_LINE_BLANKS:
                begin
                    if (b == CH_HASH)
                    begin
                        phase_next = PH_HASH_BLANKS;
                    end
                    else if (!is_blank(b))
                    begin
                        phase_next = PH_TO_EOL;
                    end
                end
                PH_HASH_BLANKS:
                begin
                    if (b == keyword_char('0))
                    begin
                        kw_next    = kw_idx_t'(1);
                        phase_next = PH_KEYWORD;
                    end
                    else if (!is_blank(b))
                    begin
                        phase_next = PH_TO_EOL;
                    end
                end
                PH_KEYWORD:
                begin
                    if (b == keyword_char(kw_reg))
                    begin
                        kw_next = kw_reg + kw_idx_t'(1);
                        if (kw_reg == KW_LAST)
                        begin
                            phase_next = PH_SEPARATOR;
                        end
                    end
                    else
                    begin
                        phase_next = PH_TO_EOL;
                    end
                end
                PH_SEPARATOR:
                begin
                    phase_next = is_blank(b) ? PH_NAME_BLANKS : PH_TO_EOL;
                end
                PH_NAME_BLANKS:
                begin
                    if (b == CH_QUOTE)
                    begin
                        qs_next    = pos_inc;
                        phase_next = PH_NAME;
                    end
                    else if (!is_blank(b))
                    begin
                        phase_next = PH_TO_EOL;
                    end
                end
                PH_NAME:
                begin
                    if (b == CH_QUOTE)
                    begin
                        ql_next    = (pos_reg >= qs_reg) ? pos_reg - qs_reg : '0;
                        phase_next = PH_MATCHED;
                    end
                end
                PH_MATCHED:
                begin
                end
                PH_TO_EOL:
                begin
                end
                default:
                begin
                    phase_next = PH_TO_EOL;
                end
            endcase
        end

        // Name fields of the result, taken before the end of text clears them.
        qs_out = qs_next;
        ql_out = ql_next;

        pos_next = (pos_reg < POS_MAX) ? pos_reg + pos_t'(1) : pos_reg;

        // End of text: report a line matched by its last byte, then start over.
        if (in_last_reg)
        begin
            if (!emit && (phase_next == PH_MATCHED))
            begin
                emit   = 1'b1;
                finish = pos_inc;
            end
            phase_next = PH_LINE_BLANKS;
            kw_next    = '0;
            pos_next   = '0;
            line_next  = LINE_FIRST;
            begin_next = '0;
            qs_next    = '0;
            ql_next    = '0;
            brk_next   = BRK_NONE;
            sat_next   = 1'b0;
        end
    end

    // Handshake: a byte leaves the input register unless its result has no room.
    assign advance  = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Running parser state, updated once per consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE_BLANKS;
            kw_reg    <= '0;
            pos_reg   <= '0;
            line_reg  <= LINE_FIRST;
            begin_reg <= '0;
            qs_reg    <= '0;
            ql_reg    <= '0;
            brk_reg   <= BRK_NONE;
            sat_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            kw_reg    <= kw_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            begin_reg <= begin_next;
            qs_reg    <= qs_next;
            ql_reg    <= ql_next;
            brk_reg   <= brk_next;
            sat_reg   <= sat_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= OUT_DATA_W'({line_reg + pos_t'(1), ql_out, qs_out,
                                         finish, begin_reg});
            out_long_reg <= sat_pos;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_long_reg;

endmodule

### rtl/idl_checker.sv
// Port-level checks for the include directive locator, bound to its top level.
// Depends on idl_pkg for the field widths and on the locator's port list.
module idl_checker
    import idl_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [0:0]            m_tuser
);

    logic [POS_W:0] name_end;
    pos_t           f_begin;
    pos_t           f_finish;
    pos_t           f_offset;
    pos_t           f_next_line;

    assign f_begin     = m_tdata[POS_W-1:0];
    assign f_finish    = m_tdata[2*POS_W-1:POS_W];
    assign f_offset    = m_tdata[3*POS_W-1:2*POS_W];
    assign f_next_line = m_tdata[5*POS_W-1:4*POS_W];
    assign name_end    = {1'b0, f_offset} + {1'b0, m_tdata[4*POS_W-1:3*POS_W]};

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // The quoted name lies inside its line.
    a_name_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (f_begin <= f_offset) && (name_end <= {1'b0, f_finish}))
        else $error("name lies outside its directive line");

    // The line after a directive is at least the second line.
    a_next_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (f_next_line >= pos_t'(2)))
        else $error("following line number below two");

endmodule

bind include_directive_locator idl_checker u_idl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### sim/tb.sv
// Self-checking testbench for include_directive_locator: streams source texts and checks
// every directive result against a scanner model kept inside this file or a typed expectation.
// Depends on idl_pkg and the locator RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 850;
    localparam int TAIL_CYCLES    = 16;
    localparam int KW_LEN         = 7;
    localparam logic [8*KW_LEN-1:0] KEYWORD = "include";

    // One directive as reported on the result side.
    typedef struct packed {
        pos_t line_begin;
        pos_t line_finish;
        pos_t name_offset;
        pos_t name_length;
        pos_t following_line;
        logic too_long;
    } directive_t;

    // One text byte request, with an optional expectation typed into the table.
    typedef struct packed {
        char_t      data;
        logic       last;
        logic       typed;
        directive_t want;
    } text_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;

    text_req_t  cur_req = '0;
    text_req_t  text_rows[$];
    directive_t pending_directives[$];
    int         mismatches = 0;
    int         burst_left = 0;
    logic       draining = 1'b0;

    // Scanner model state.
    phase_t      scan_ph;
    int unsigned kw_pos;
    pos_t        byte_pos;
    pos_t        line_no;
    pos_t        line_start;
    pos_t        quote_start;
    pos_t        quote_len;
    brk_t        prev_brk;
    logic        overflowed;

    include_directive_locator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offsets never pass the maximum text size.
    function automatic pos_t next_pos(input pos_t v);
        return (v == POS_MAX) ? v : v + pos_t'(1);
    endfunction

    // Start of a new text: line 1 at offset 0.
    function automatic void restart_text();
        scan_ph     = PH_LINE_BLANKS;
        kw_pos      = 0;
        byte_pos    = '0;
        line_no     = LINE_FIRST;
        line_start  = '0;
        quote_start = '0;
        quote_len   = '0;
        prev_brk    = BRK_NONE;
        overflowed  = 1'b0;
    endfunction

    // Advances the scanner by one byte; returns 1 when a directive line completes.
    function automatic logic locate_directive(input char_t b, input logic last,
                                              output directive_t res);
        pos_t  pos;
        logic  found;
        logic  is_brk;
        logic  blank;
        char_t kw_char;
        pos     = byte_pos;
        found   = 1'b0;
        res     = '0;
        is_brk  = (b == CH_CR) || (b == CH_LF);
        blank   = (b == CH_SPACE) || (b == CH_TAB);
        kw_char = (kw_pos < KW_LEN) ? KEYWORD[8*(KW_LEN-1-kw_pos) +: 8] : 8'h00;

        if (pos >= POS_MAX)
            overflowed = 1'b1;

        if ((prev_brk == BRK_CR && b == CH_LF) || (prev_brk == BRK_LF && b == CH_CR))
        begin
            // Second half of a CR LF or LF CR pair.
            prev_brk   = BRK_NONE;
            line_start = next_pos(pos);
        end
        else if (is_brk)
        begin
            if (scan_ph == PH_MATCHED)
            begin
                res = directive_t'{line_start, pos, quote_start, quote_len,
                                   pos_t'(line_no + 1), overflowed};
                found = 1'b1;
            end
            prev_brk = (b == CH_CR) ? BRK_CR : BRK_LF;
            if (line_no < LINE_MAX)
                line_no = line_no + pos_t'(1);
            else
                overflowed = 1'b1;
            line_start = next_pos(pos);
            scan_ph    = PH_LINE_BLANKS;
            kw_pos     = 0;
        end
        else
        begin
            prev_brk = BRK_NONE;
            case (scan_ph)
                PH_LINE_BLANKS:
                    if (b == CH_HASH)
                        scan_ph = PH_HASH_BLANKS;
                    else if (!blank)
                        scan_ph = PH_TO_EOL;
                PH_HASH_BLANKS:
                    if (b == KEYWORD[8*KW_LEN-1 -: 8])
                    begin
                        kw_pos  = 1;
                        scan_ph = PH_KEYWORD;
                    end
                    else if (!blank)
                        scan_ph = PH_TO_EOL;
                PH_KEYWORD:
                    if (kw_pos < KW_LEN && b == kw_char)
                    begin
                        kw_pos = kw_pos + 1;
                        if (kw_pos >= KW_LEN)
                            scan_ph = PH_SEPARATOR;
                    end
                    else
                        scan_ph = PH_TO_EOL;
                PH_SEPARATOR:
                    scan_ph = blank ? PH_NAME_BLANKS : PH_TO_EOL;
                PH_NAME_BLANKS:
                    if (b == CH_QUOTE)
                    begin
                        quote_start = next_pos(pos);
                        scan_ph     = PH_NAME;
                    end
                    else if (!blank)
                        scan_ph = PH_TO_EOL;
                PH_NAME:
                    if (b == CH_QUOTE)
                    begin
                        quote_len = (pos >= quote_start) ? pos - quote_start : '0;
                        scan_ph   = PH_MATCHED;
                    end
                PH_MATCHED:
                    ;
                default:
                    scan_ph = PH_TO_EOL;
            endcase
        end

        if (byte_pos < POS_MAX)
            byte_pos = byte_pos + pos_t'(1);

        // The text ends here; a matched line without a break ends at the text length.
        if (last)
        begin
            if (!found && scan_ph == PH_MATCHED)
            begin
                res = directive_t'{line_start, next_pos(pos), quote_start, quote_len,
                                   pos_t'(line_no + 1), overflowed};
                found = 1'b1;
            end
            restart_text();
        end
        return found;
    endfunction

    task automatic check_field(input string name, input pos_t want,
                               input pos_t got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result checking and prediction, both on accepted requests.
    always @(posedge clk)
    begin : monitor
        directive_t want;
        directive_t seen;
        logic       found;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_directives.size() == 0)
                begin
                    $error("result request with no directive expected");
                    mismatches++;
                end
                else
                begin
                    want = pending_directives.pop_front();
                    check_field("line_begin", want.line_begin, m_tdata[0*POS_W +: POS_W]);
                    check_field("line_finish", want.line_finish, m_tdata[1*POS_W +: POS_W]);
                    check_field("name_offset", want.name_offset, m_tdata[2*POS_W +: POS_W]);
                    check_field("name_length", want.name_length, m_tdata[3*POS_W +: POS_W]);
                    check_field("following_line", want.following_line,
                                m_tdata[4*POS_W +: POS_W]);
                    check_field("too_long", pos_t'(want.too_long), pos_t'(m_tuser[0]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                found = locate_directive(cur_req.data, cur_req.last, seen);
                if (cur_req.typed)
                    pending_directives.push_back(cur_req.want);
                else if (found)
                    pending_directives.push_back(seen);
            end
        end
    end

    // Receiver: picks a new stall mode whenever its random window runs out.
    always @(posedge clk)
    begin : receiver
        int mode;
        int window;
        if (window <= 0)
        begin
            mode   = $urandom_range(0, 3);
            window = $urandom_range(16, 96);
        end
        else
            window--;
        if (draining)
            m_tready <= 1'b1;
        else
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ~m_tready;
                2:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= (window % 8 == 0);
            endcase
    end

    // Watchdog: too many cycles in a row with no request accepted on either side.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[include_directive_locator] ERROR");
        $finish;
    end

    // Mixed byte: mostly the characters the scanner reacts to.
    function automatic char_t pick_byte();
        char_t b;
        int    k;
        k = $urandom_range(0, KW_LEN - 1);
        case ($urandom_range(0, 9))
            0:       b = CH_CR;
            1:       b = CH_LF;
            2:       b = CH_SPACE;
            3:       b = CH_TAB;
            4:       b = CH_HASH;
            5:       b = CH_QUOTE;
            6:       b = KEYWORD[8*k +: 8];
            default: b = char_t'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    function automatic char_t pick_blank();
        return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
    endfunction

    // Any byte that neither breaks the line nor closes the name.
    function automatic char_t pick_name_byte();
        char_t b;
        b = char_t'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_CR || b == CH_LF)
            b = 8'h2E;
        return b;
    endfunction

    task automatic put_byte(input char_t d, input logic last, input logic typed,
                            input directive_t want);
        text_req_t r;
        r.data  = d;
        r.last  = last;
        r.typed = typed;
        r.want  = want;
        text_rows.push_back(r);
    endtask

    task automatic add_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], last && (i == s.len() - 1), 1'b0, '0);
    endtask

    // Holds the byte on the bus until the block takes it.
    task automatic send_req(input text_req_t r);
        s_tvalid <= 1'b1;
        s_tdata  <= r.data;
        s_tlast  <= r.last;
        cur_req  <= r;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Sends the queued bytes in bursts with random gaps.
    task automatic play_rows();
        int gap;
        while (text_rows.size() != 0)
        begin
            if (burst_left <= 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            send_req(text_rows.pop_front());
            burst_left--;
        end
    endtask

    // Stops sending until every expected directive has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_directives.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        text_req_t r;
        char_t     line_q[$];
        int        sent;
        int        lines;
        int        kind;
        int        idx;
        restart_text();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directive closed by the last byte of the text, name holding 00 and FF.
        add_text("#include \"", 1'b0);
        put_byte(8'h00, 1'b0, 1'b0, '0);
        put_byte(8'hFF, 1'b0, 1'b0, '0);
        put_byte(CH_QUOTE, 1'b1, 1'b1,
                 directive_t'{21'd0, 21'd13, 21'd10, 21'd2, 21'd2, 1'b0});
        // LF CR pair, tabs as blanks, an empty name, CR as the last byte.
        add_text("\n\r\t#include\t\"\"", 1'b0);
        put_byte(CH_CR, 1'b1, 1'b1,
                 directive_t'{21'd2, 21'd14, 21'd13, 21'd0, 21'd3, 1'b0});
        play_rows();
        wait_idle();

        // A directive followed by an empty line, ending the text.
        add_text("#include \"x\"\n\n", 1'b1);
        play_rows();

        // Random texts built from directive lines, broken lines and noise.
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            lines = $urandom_range(1, 6);
            for (int ln = 0; ln < lines; ln++)
            begin
                line_q.delete();
                kind = $urandom_range(0, 11);
                if (kind < 11)
                begin
                    repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
                    line_q.push_back(CH_HASH);
                    repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
                    for (int k = KW_LEN - 1; k >= 0; k--)
                        line_q.push_back(KEYWORD[8*k +: 8]);
                    // With kind 10 the keyword runs straight into the line break.
                    if (kind != 10)
                    begin
                        line_q.push_back(pick_blank());
                        repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
                        line_q.push_back(CH_QUOTE);
                        repeat ($urandom_range(0, 5)) line_q.push_back(pick_name_byte());
                        // Kind 9 leaves the name open.
                        if (kind != 9)
                            line_q.push_back(CH_QUOTE);
                        repeat ($urandom_range(0, 3)) line_q.push_back(pick_name_byte());
                    end
                    // Kinds 7 and 8 damage one byte of the line.
                    if (kind == 7 || kind == 8)
                    begin
                        idx = $urandom_range(0, line_q.size() - 1);
                        line_q[idx] = pick_byte();
                    end
                end
                else
                    repeat ($urandom_range(0, 12)) line_q.push_back(pick_byte());

                // Line end: single break, pair, double break, or end of text.
                case ($urandom_range(0, 7))
                    0, 1:
                    begin
                        line_q.push_back(CH_CR);
                        line_q.push_back(CH_LF);
                    end
                    2: line_q.push_back(CH_LF);
                    3: line_q.push_back(CH_CR);
                    4:
                    begin
                        line_q.push_back(CH_LF);
                        line_q.push_back(CH_CR);
                    end
                    5:
                    begin
                        line_q.push_back(CH_CR);
                        line_q.push_back(CH_CR);
                    end
                    6:
                    begin
                        line_q.push_back(CH_LF);
                        line_q.push_back(CH_LF);
                    end
                    default:
                        if (ln != lines - 1)
                            line_q.push_back(CH_LF);
                endcase
                foreach (line_q[j])
                    put_byte(line_q[j], 1'b0, 1'b0, '0);
                sent += line_q.size();
            end
            if (text_rows.size() == 0)
            begin
                put_byte(pick_byte(), 1'b0, 1'b0, '0);
                sent++;
            end
            r      = text_rows.pop_back();
            r.last = 1'b1;
            text_rows.push_back(r);
            play_rows();
            if ($urandom_range(0, 7) == 0)
                wait_idle();
        end

        // Drain with the receiver always ready, then report.
        draining <= 1'b1;
        wait_idle();
        if (mismatches == 0)
            $display("[include_directive_locator] OK");
        else
            $display("[include_directive_locator] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/idl_pkg.sv
rtl/include_directive_locator.sv
rtl/idl_checker.sv
sim/tb.sv
